// ===== design/slbs_pkg.sv =====
package slbs_pkg;

  // Table entries: 0 standby, 1..5 one per status flag bit
  localparam int NUM_PATTERNS = 6;
  localparam int THROTTLE_MS  = 10;

  localparam int NOW_W   = 32;
  localparam int FLAGS_W = 5;
  localparam int LEN_W   = 16;
  localparam int SEL_W   = 3;
  localparam int CNT_W   = 5;

  typedef logic [1:0] stage_t;

  localparam stage_t ST_OFF      = 2'd0;
  localparam stage_t ST_ON       = 2'd1;
  localparam stage_t ST_GAP      = 2'd2;
  localparam stage_t ST_INTERVAL = 2'd3;

  localparam logic [SEL_W-1:0] PAT_STANDBY = 3'd0;
  localparam logic [CNT_W-1:0] CNT_MAX     = 5'd31;

  function automatic logic [LEN_W-1:0] tbl_len(input logic [SEL_W-1:0] sel);
    logic [LEN_W-1:0] v;
    unique case (sel)
      3'd0:                      v = 16'd100;
      3'd1:                      v = 16'd50;
      3'd2, 3'd3, 3'd4, 3'd5:    v = 16'd100;
      default:                   v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [LEN_W-1:0] tbl_gap(input logic [SEL_W-1:0] sel);
    logic [LEN_W-1:0] v;
    unique case (sel)
      3'd0:                      v = 16'd300;
      3'd1:                      v = 16'd50;
      3'd2, 3'd3, 3'd4, 3'd5:    v = 16'd300;
      default:                   v = 16'd0;
    endcase
    return v;
  endfunction

  // Entry 0 takes its interval from the standby register instead
  function automatic logic [LEN_W-1:0] tbl_ivl(input logic [SEL_W-1:0] sel);
    logic [LEN_W-1:0] v;
    unique case (sel)
      3'd1:                      v = 16'd1000;
      3'd2, 3'd3, 3'd4, 3'd5:    v = 16'd2000;
      default:                   v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] tbl_cnt(input logic [SEL_W-1:0] sel);
    logic [CNT_W-1:0] v;
    unique case (sel)
      3'd0:    v = 5'd1;
      3'd1:    v = 5'd20;
      3'd2:    v = 5'd1;
      3'd3:    v = 5'd5;
      3'd4:    v = 5'd3;
      3'd5:    v = 5'd2;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  function automatic logic [FLAGS_W-1:0] tbl_flag(input logic [SEL_W-1:0] sel);
    logic [FLAGS_W-1:0] v;
    unique case (sel)
      3'd1:    v = 5'b00001;
      3'd2:    v = 5'b00010;
      3'd3:    v = 5'b00100;
      3'd4:    v = 5'b01000;
      3'd5:    v = 5'b10000;
      default: v = 5'b00000;
    endcase
    return v;
  endfunction

endpackage

// ===== design/status_led_blink_sequencer.sv =====
// Channel   Dir  Handshake                  Payload (lowest bit first)
// s_axis    in   s_axis_tvalid/tready       tdata: now_ms[31:0], status_flags[36:32]
// m_axis    out  m_axis_tvalid/tready       tdata: led_on, pattern_active,
//                                           blink_stage[1:0], pattern_index[2:0]
// cfg       in   cfg_we (no back-pressure)  cfg_wdata: standby_interval_ms
//
// Hold each tick transaction in the input register, evaluate it against the
// sequencer state in one pass and register its result at the output as it moves
// on: one transaction per cycle, back to back, while the output is not stalled.
// A stalled output holds the tick in the input register; the input still takes
// a new tick in any cycle in which the held one moves on.
// Reset (rst, synchronous) clears the sequencer state, standby interval and valid flags.

module status_led_blink_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // now_ms[31:0], status_flags[36:32], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // led_on, pattern_active, blink_stage[1:0],
                                      // pattern_index[2:0], zero pad
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import slbs_pkg::*;

  // Input register
  logic               in_valid;
  logic [NOW_W-1:0]   in_now;
  logic [FLAGS_W-1:0] in_flags;

  // Sequencer state
  logic [LEN_W-1:0]   standby_interval_ms;
  logic [NOW_W-1:0]   last_update_ms,    last_update_ms_next;
  logic [NOW_W-1:0]   stage_timer_ms,    stage_timer_ms_next;
  logic [LEN_W-1:0]   current_length_ms, current_length_ms_next;
  stage_t             stage,             stage_next;
  logic [CNT_W-1:0]   blink_count,       blink_count_next;
  logic               running,           running_next;
  logic [SEL_W-1:0]   selected_pattern,  selected_pattern_next;
  logic               led_level,         led_level_next;

  logic               fire;
  logic [NOW_W-1:0]   diff;
  logic [NOW_W:0]     timer_sum;
  logic [SEL_W-1:0]   pick;
  logic               pick_hit;
  logic [SEL_W:0]     cand;

  // Move the held tick on whenever the output register is free or draining
  assign fire          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_now   <= s_axis_tdata[NOW_W-1:0];
      in_flags <= s_axis_tdata[NOW_W+FLAGS_W-1:NOW_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      standby_interval_ms <= '0;
    end else if (cfg_we) begin
      standby_interval_ms <= cfg_wdata;
    end
  end

  assign diff = in_now - last_update_ms;

  // Round-robin pick: candidates after the last shown entry, first set flag wins.
  // Walk from the far end down so the nearest hit is written last.
  always_comb begin
    pick     = selected_pattern;
    pick_hit = 1'b0;
    cand     = '0;
    for (int i = NUM_PATTERNS; i >= 1; i--) begin
      cand = {1'b0, selected_pattern} + (SEL_W+1)'(i);
      if (cand >= (SEL_W+1)'(NUM_PATTERNS)) begin
        cand = cand - (SEL_W+1)'(NUM_PATTERNS);
      end
      if ((tbl_flag(cand[SEL_W-1:0]) & in_flags) != '0) begin
        pick     = cand[SEL_W-1:0];
        pick_hit = 1'b1;
      end
    end
  end

  always_comb begin
    last_update_ms_next    = last_update_ms;
    stage_timer_ms_next    = stage_timer_ms;
    current_length_ms_next = current_length_ms;
    stage_next             = stage;
    blink_count_next       = blink_count;
    running_next           = running;
    selected_pattern_next  = selected_pattern;
    led_level_next         = led_level;
    timer_sum              = '0;

    // Ticks inside the throttle window leave everything as it is
    if (diff >= NOW_W'(THROTTLE_MS)) begin
      last_update_ms_next = in_now;

      if (in_flags != '0) begin
        if (!running && pick_hit) begin
          selected_pattern_next = pick;
          running_next          = 1'b1;
          stage_next            = ST_OFF;
          blink_count_next      = '0;
          stage_timer_ms_next   = '0;
        end
      end else if (standby_interval_ms != '0) begin
        // A running pattern carries on; only the selection drops to standby
        selected_pattern_next = PAT_STANDBY;
        if (!running) begin
          running_next        = 1'b1;
          stage_next          = ST_OFF;
          blink_count_next    = '0;
          stage_timer_ms_next = '0;
        end
      end

      if (running_next) begin
        // The on stage keeps the length loaded in the off stage before it
        unique case (stage_next)
          ST_OFF:      current_length_ms_next = tbl_len(selected_pattern_next);
          ST_GAP:      current_length_ms_next = tbl_gap(selected_pattern_next);
          ST_INTERVAL: current_length_ms_next = (selected_pattern_next == PAT_STANDBY) ?
                                                standby_interval_ms :
                                                tbl_ivl(selected_pattern_next);
          default:     current_length_ms_next = current_length_ms;
        endcase

        // Widened sum so a long silence cannot wrap the timer
        timer_sum = {1'b0, stage_timer_ms_next} + {1'b0, diff};
        if (timer_sum >= (NOW_W+1)'(current_length_ms_next)) begin
          stage_timer_ms_next = '0;
          unique case (stage_next)
            ST_OFF: begin
              led_level_next = 1'b1;
              stage_next     = ST_ON;
            end
            ST_ON: begin
              led_level_next = 1'b0;
              if (blink_count_next != CNT_MAX) begin
                blink_count_next = blink_count_next + CNT_W'(1);
              end
              if (blink_count_next >= tbl_cnt(selected_pattern_next)) begin
                blink_count_next = '0;
                stage_next       = ST_INTERVAL;
              end else begin
                stage_next = ST_GAP;
              end
            end
            ST_GAP: begin
              stage_next = ST_OFF;
            end
            default: begin
              // End of the interval ends the pattern; stage stays at interval
              running_next = 1'b0;
            end
          endcase
        end else begin
          stage_timer_ms_next = timer_sum[NOW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_update_ms    <= '0;
      stage_timer_ms    <= '0;
      current_length_ms <= '0;
      stage             <= ST_OFF;
      blink_count       <= '0;
      running           <= 1'b0;
      selected_pattern  <= PAT_STANDBY;
      led_level         <= 1'b0;
    end else if (fire) begin
      last_update_ms    <= last_update_ms_next;
      stage_timer_ms    <= stage_timer_ms_next;
      current_length_ms <= current_length_ms_next;
      stage             <= stage_next;
      blink_count       <= blink_count_next;
      running           <= running_next;
      selected_pattern  <= selected_pattern_next;
      led_level         <= led_level_next;
    end
  end

  // Output register: show the state as it stands after the tick
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (fire) begin
      m_axis_tdata <= {1'b0, selected_pattern_next, stage_next, running_next, led_level_next};
    end
  end

endmodule

// ===== sim/status_led_blink_sequencer_tb.sv =====
`timescale 1ns / 100ps

module status_led_blink_sequencer_tb;
  import slbs_pkg::*;

  // Generous ceiling: ~1220 ticks, plus settling
  localparam int RUN_LIMIT = 400000;

  // Result layout on m_axis_tdata[6:0], lowest bit last in this list
  typedef struct packed {
    logic [SEL_W-1:0] pattern_index;
    stage_t           blink_stage;
    logic             pattern_active;
    logic             led_on;
  } led_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // now_ms[31:0], status_flags[36:32], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // led_on, pattern_active, blink_stage[1:0],
                                    // pattern_index[2:0], zero pad
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  status_led_blink_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Blink sequencer predictor: its own copy of the pattern table and state
  // ---------------------------------------------------------------------------
  // Per entry: 0 standby, 1..5 one per status bit in flag order
  logic [15:0] on_len_ms   [0:5] = '{16'd100, 16'd50, 16'd100, 16'd100, 16'd100, 16'd100};
  logic [15:0] gap_len_ms  [0:5] = '{16'd300, 16'd50, 16'd300, 16'd300, 16'd300, 16'd300};
  logic [15:0] pause_len_ms[0:5] = '{16'd0, 16'd1000, 16'd2000, 16'd2000, 16'd2000, 16'd2000};
  logic [4:0]  blinks_per  [0:5] = '{5'd1, 5'd20, 5'd1, 5'd5, 5'd3, 5'd2};

  logic [15:0]      standby_ms     = '0;
  logic [31:0]      blink_last_ms  = '0;
  logic [31:0]      blink_timer_ms = '0;
  logic [15:0]      blink_len_ms   = '0;
  stage_t           blink_stage_q  = ST_OFF;
  logic [4:0]       blink_reps     = '0;
  logic             blink_running  = 1'b0;
  logic [SEL_W-1:0] blink_sel      = '0;
  logic             blink_led      = 1'b0;

  // Coverage tallies for the summary
  int ticks_sent      = 0;
  int throttled_ticks = 0;
  int pattern_starts [0:5] = '{0, 0, 0, 0, 0, 0};

  function automatic void begin_pattern();
    blink_running  = 1'b1;
    blink_stage_q  = ST_OFF;
    blink_reps     = '0;
    blink_timer_ms = '0;
    pattern_starts[blink_sel]++;
  endfunction

  // Advance the predicted sequencer by one tick and return the LED status seen
  function automatic led_result_t predict_led_status(input logic [31:0] now,
                                                     input logic [4:0]  flags);
    logic [31:0] elapsed;
    logic [32:0] total;
    int          cand;
    bit          found;
    led_result_t r;
    elapsed = now - blink_last_ms;
    found   = 1'b0;
    if (elapsed < THROTTLE_MS) begin
      throttled_ticks++;
    end else begin
      blink_last_ms = now;
      if (flags != '0) begin
        // Round robin after the entry last shown; stop at the first hit
        if (!blink_running) begin
          for (int i = 1; i <= NUM_PATTERNS && !found; i++) begin
            cand = (int'(blink_sel) + i) % NUM_PATTERNS;
            if (cand != 0 && flags[cand-1]) begin
              blink_sel = cand[SEL_W-1:0];
              found     = 1'b1;
              begin_pattern();
            end
          end
        end
      end else if (standby_ms != '0) begin
        // Standby takes the selection, even over a pattern still running
        blink_sel = PAT_STANDBY;
        if (!blink_running)
          begin_pattern();
      end

      if (blink_running) begin
        // The on stage keeps the length loaded in the off stage before it
        case (blink_stage_q)
          ST_OFF:      blink_len_ms = on_len_ms[blink_sel];
          ST_GAP:      blink_len_ms = gap_len_ms[blink_sel];
          ST_INTERVAL: blink_len_ms = (blink_sel == PAT_STANDBY) ? standby_ms
                                                                 : pause_len_ms[blink_sel];
          default: ;
        endcase
        // Compare without wrap: a long gap may carry past 2^32
        total = {1'b0, blink_timer_ms} + {1'b0, elapsed};
        if (total >= {17'd0, blink_len_ms}) begin
          blink_timer_ms = '0;
          case (blink_stage_q)
            ST_OFF: begin
              blink_led     = 1'b1;
              blink_stage_q = ST_ON;
            end
            ST_ON: begin
              blink_led = 1'b0;
              if (blink_reps < CNT_MAX)
                blink_reps++;
              if (blink_reps >= blinks_per[blink_sel]) begin
                blink_reps    = '0;
                blink_stage_q = ST_INTERVAL;
              end else begin
                blink_stage_q = ST_GAP;
              end
            end
            ST_GAP: blink_stage_q = ST_OFF;
            default: blink_running = 1'b0;   // interval done: stage stays put
          endcase
        end else begin
          blink_timer_ms = total[31:0];
        end
      end
    end
    r.led_on         = blink_led;
    r.pattern_active = blink_running;
    r.blink_stage    = blink_stage_q;
    r.pattern_index  = blink_sel;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender, receiver and result checking
  // ---------------------------------------------------------------------------
  led_result_t expected_leds[$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  logic [31:0] clock_ms       = '0;
  int          tx_burst_left  = 0;
  bit          tx_idle_en     = 1'b1;
  bit          rx_stall_en    = 1'b1;
  int          rx_hold_left   = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Send one tick transaction; return at the edge that accepts it, valid still high
  task automatic send_tick(input logic [31:0] now, input logic [4:0] flags);
    int gap;
    gap = 0;
    if (tx_idle_en && tx_burst_left == 0) begin
      gap           = $urandom_range(1, 6);
      tx_burst_left = $urandom_range(1, 20);
    end
    if (tx_burst_left > 0)
      tx_burst_left--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {3'b000, flags, now};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    clock_ms = now;
    ticks_sent++;
    expected_leds.push_back(predict_led_status(now, flags));
  endtask

  task automatic tick_after(input logic [31:0] delta, input logic [4:0] flags);
    send_tick(clock_ms + delta, flags);
  endtask

  // Drop valid and wait until every predicted status has come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_leds.size() != 0) @(posedge clk);
  endtask

  // Write the standby interval only with nothing in flight
  task automatic set_standby(input logic [15:0] value);
    settle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we     <= 1'b0;
    standby_ms  = value;
  endtask

  // Receiver: ready for a random run, then stall for a random run
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left--;
    end else if (m_axis_tready && rx_stall_en) begin
      m_axis_tready <= 1'b0;
      rx_hold_left   = $urandom_range(0, 4);
    end else begin
      m_axis_tready <= 1'b1;
      rx_hold_left   = $urandom_range(0, 12);
    end
  end

  // Compare every result transaction with the oldest prediction
  always @(posedge clk) begin
    led_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[6:0];
      if (expected_leds.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result with no tick outstanding: led=%0b active=%0b stage=%0d idx=%0d",
                   $time, got.led_on, got.pattern_active, got.blink_stage, got.pattern_index);
        mismatch_count++;
      end else begin
        want = expected_leds.pop_front();
        if (got.led_on !== want.led_on || got.pattern_active !== want.pattern_active ||
            got.blink_stage !== want.blink_stage ||
            got.pattern_index !== want.pattern_index) begin
          if (mismatch_count < 10)
            $display("%0t: expected led=%0b active=%0b stage=%0d idx=%0d, got led=%0b active=%0b stage=%0d idx=%0d",
                     $time, want.led_on, want.pattern_active, want.blink_stage,
                     want.pattern_index, got.led_on, got.pattern_active, got.blink_stage,
                     got.pattern_index);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Throttle edges, counter wrap, long gaps and round-robin pick, standby off
  task automatic test_throttle_and_wrap();
    send_tick(32'd0, 5'h00);          // no time passed since reset: ignored
    send_tick(32'd9, 5'h02);          // one short of the throttle window
    send_tick(32'd10, 5'h02);         // exactly on the window: low battery starts
    send_tick(32'd50, 5'h00);         // status gone, standby off: pattern carries on
    send_tick(32'hFFFF_FFF0, 5'h1F);  // huge jump on top of a part-run stage timer
    send_tick(32'h0000_0002, 5'h00);  // millisecond counter wraps
    send_tick(32'h0000_0100, 5'h00);
    send_tick(32'h0000_0200, 5'h00);
    send_tick(32'h0000_0A00, 5'h00);  // interval runs out, pattern ends
    send_tick(32'h0000_0A10, 5'h1F);  // every status: next after low battery wins
    send_tick(32'h0000_0A15, 5'h1F);  // throttled while running
    send_tick(32'h8000_0000, 5'h10);
    send_tick(32'h7FFF_FFFF, 5'h08);  // time runs backwards: reads as a long gap
  endtask

  // Standby grabs the selection mid-pattern, then runs on its own
  task automatic test_standby_takeover();
    set_standby(16'd1);
    tick_after(32'd300, 5'h00);
    tick_after(32'd150, 5'h00);
    tick_after(32'd10, 5'h00);        // standby on stage still running
    tick_after(32'd10, 5'h00);        // no status: standby pattern carries on
    tick_after(32'd5, 5'h00);
    tick_after(32'd400, 5'h00);
    tick_after(32'd11, 5'h04);        // status appears while standby runs; one millisecond interval ends at once
    tick_after(32'd400, 5'h04);
  endtask

  function automatic logic [4:0] random_flags();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3)
      return 5'h00;
    else if (pick < 7)
      return 5'h01 << $urandom_range(0, 4);
    else
      return 5'($urandom);
  endfunction

  // Mostly steady status with stage-sized time steps; throttled ticks,
  // window edges, long gaps and jumps anywhere as noise
  task automatic test_random_sequences(input logic [15:0] standby, input int count,
                                       input int step_max, input bit idle_en);
    logic [4:0] live_flags;
    int         pick;
    set_standby(standby);
    tx_idle_en  = idle_en;
    rx_stall_en = idle_en;
    live_flags  = random_flags();
    repeat (count) begin
      if ($urandom_range(0, 99) < 8)
        live_flags = random_flags();
      pick = $urandom_range(0, 99);
      if (pick < 15)
        tick_after($urandom_range(0, 9), live_flags);
      else if (pick < 25)
        tick_after($urandom_range(9, 11), live_flags);
      else if (pick < 93)
        tick_after($urandom_range(10, step_max), live_flags);
      else if (pick < 98)
        tick_after($urandom_range(1000, 70000), live_flags);
      else
        send_tick($urandom, live_flags);
    end
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  // Abort on a hung handshake
  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, expected_leds.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_standby(16'd0);
    test_throttle_and_wrap();
    test_standby_takeover();
    test_random_sequences(16'hFFFF, 200, 4000, 1'b1);
    test_random_sequences(16'h0000, 200, 150, 1'b1);
    test_random_sequences(16'd1, 200, 150, 1'b0);
    test_random_sequences(16'($urandom_range(2, 65534)), 200, 1500, 1'b1);
    test_random_sequences(16'd300, 200, 200, 1'b1);
    test_random_sequences(16'h0000, 200, 150, 1'b0);

    settle();
    repeat (8) @(posedge clk);

    $display("Covered %0d ticks (%0d throttled) over standby settings 0, 1, 300, 65535 and random",
             ticks_sent, throttled_ticks);
    $display("Pattern starts: standby %0d, loading %0d, battery %0d, sensor %0d, link %0d, server %0d",
             pattern_starts[0], pattern_starts[1], pattern_starts[2], pattern_starts[3],
             pattern_starts[4], pattern_starts[5]);
    if (mismatch_count == 0 && expected_leds.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, expected_leds.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/slbs_pkg.sv
design/status_led_blink_sequencer.sv
sim/status_led_blink_sequencer_tb.sv
